[sv/fxalu_pkg.sv]
// Package for the Q24.8 fixed-point arithmetic unit.
// Holds the item types, opcodes and word constants; depends on nothing.
`timescale 1ns / 1ps

package fxalu_pkg;

  localparam int WORD_W        = 32;
  localparam int FRAC_BITS_DEF = 8;
  localparam int PROD_W        = 2 * WORD_W;

  localparam logic [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_LT, OP_GE, OP_LE,
    OP_EQ, OP_NE, OP_INC, OP_DEC, OP_MIN, OP_MAX, OP_TO_INT, OP_FROM_INT
  } op_t;

  typedef struct packed {
    logic [3:0]               opcode;
    logic signed [WORD_W-1:0] operand_a;
    logic signed [WORD_W-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] result_value;
    logic                     compare_true;
    logic                     divide_by_zero;
  } rsp_t;

  typedef struct packed {
    op_t               op;
    logic              neg;
    logic              dz;
    logic              cmp;
    logic [WORD_W-1:0] simple;
    logic [PROD_W-1:0] prod;
  } meta_t;

endpackage

[sv/fixed_point_alu_q24_8_unit.sv]
// Top level of the signed Q24.8 fixed-point arithmetic unit.
// Depends on fxalu_pkg, fxalu_prep, fxalu_div_cell and fxalu_finish.
// The unit takes one item per cycle and returns one result per item, in order.
// Every item passes through the same path: an input register, a front stage
// holding the multiplier, one divider cell per quotient bit and an output
// register. A stall on the result side holds the whole chain.
`timescale 1ns / 1ps

module fixed_point_alu_q24_8_unit #(
  parameter int FRAC_BITS = fxalu_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  fxalu_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output fxalu_pkg::rsp_t rsp
);

  localparam int NUM_W = fxalu_pkg::WORD_W + FRAC_BITS;

  logic                         en;
  logic                         s0_valid;
  fxalu_pkg::req_t              s0;
  fxalu_pkg::meta_t             prep_meta;
  logic [NUM_W-1:0]             prep_num;
  logic [fxalu_pkg::WORD_W-1:0] prep_den;
  fxalu_pkg::rsp_t              fin_rsp;

  logic                         c_valid [0:NUM_W];
  fxalu_pkg::meta_t             c_meta  [0:NUM_W];
  logic [fxalu_pkg::WORD_W-1:0] c_rem   [0:NUM_W];
  logic [NUM_W-1:0]             c_nq    [0:NUM_W];
  logic [fxalu_pkg::WORD_W-1:0] c_den   [0:NUM_W];

  assign en        = !rsp_valid || rsp_ready;
  assign req_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid   <= 1'b0;
      c_valid[0] <= 1'b0;
      rsp_valid  <= 1'b0;
    end else if (en) begin
      s0_valid   <= req_valid;
      c_valid[0] <= s0_valid;
      rsp_valid  <= c_valid[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0        <= req;
      c_meta[0] <= prep_meta;
      c_nq[0]   <= prep_num;
      c_den[0]  <= prep_den;
      rsp       <= fin_rsp;
    end
  end

  assign c_rem[0] = '0;

  fxalu_prep #(.FRAC_BITS(FRAC_BITS), .NUM_W(NUM_W)) u_prep (
    .req  (s0),
    .meta (prep_meta),
    .num  (prep_num),
    .den  (prep_den)
  );

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    fxalu_div_cell #(.NUM_W(NUM_W)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .valid_prev (c_valid[i]),
      .meta_prev  (c_meta[i]),
      .rem_prev   (c_rem[i]),
      .nq_prev    (c_nq[i]),
      .den_prev   (c_den[i]),
      .valid      (c_valid[i+1]),
      .meta       (c_meta[i+1]),
      .rem        (c_rem[i+1]),
      .nq         (c_nq[i+1]),
      .den        (c_den[i+1])
    );
  end

  fxalu_finish #(.FRAC_BITS(FRAC_BITS), .NUM_W(NUM_W)) u_finish (
    .meta (c_meta[NUM_W]),
    .rem  (c_rem[NUM_W]),
    .quo  (c_nq[NUM_W]),
    .den  (c_den[NUM_W]),
    .rsp  (fin_rsp)
  );

endmodule

[sv/fxalu_prep.sv]
// Front stage of the fixed-point unit: simple operations, the magnitude product
// and the divider set-up. Depends on fxalu_pkg.
`timescale 1ns / 1ps

module fxalu_prep #(
  parameter int FRAC_BITS = fxalu_pkg::FRAC_BITS_DEF,
  parameter int NUM_W     = fxalu_pkg::WORD_W + FRAC_BITS
) (
  input  fxalu_pkg::req_t                 req,
  output fxalu_pkg::meta_t                meta,
  output logic [NUM_W-1:0]                num,
  output logic [fxalu_pkg::WORD_W-1:0]    den
);

  logic signed [fxalu_pkg::WORD_W-1:0] a;
  logic signed [fxalu_pkg::WORD_W-1:0] b;
  logic [fxalu_pkg::WORD_W-1:0]        mag_a;
  logic [fxalu_pkg::WORD_W-1:0]        mag_b;
  logic [fxalu_pkg::WORD_W:0]          sum;
  logic [fxalu_pkg::WORD_W:0]          diff;
  fxalu_pkg::op_t                      op;

  assign a     = req.operand_a;
  assign b     = req.operand_b;
  assign op    = fxalu_pkg::op_t'(req.opcode);
  assign mag_a = a[fxalu_pkg::WORD_W-1] ? fxalu_pkg::WORD_W'(-a) : a;
  assign mag_b = b[fxalu_pkg::WORD_W-1] ? fxalu_pkg::WORD_W'(-b) : b;
  assign sum   = {a[fxalu_pkg::WORD_W-1], a} + {b[fxalu_pkg::WORD_W-1], b};
  assign diff  = {a[fxalu_pkg::WORD_W-1], a} - {b[fxalu_pkg::WORD_W-1], b};
  assign num   = {mag_a, {FRAC_BITS{1'b0}}};
  assign den   = mag_b;

  always_comb begin
    meta.op     = op;
    meta.neg    = a[fxalu_pkg::WORD_W-1] ^ b[fxalu_pkg::WORD_W-1];
    meta.dz     = (op == fxalu_pkg::OP_DIV) && (b == '0);
    meta.cmp    = 1'b0;
    meta.simple = '0;
    meta.prod   = fxalu_pkg::PROD_W'(mag_a) * fxalu_pkg::PROD_W'(mag_b);
    unique case (op)
      fxalu_pkg::OP_ADD: begin
        if (sum[fxalu_pkg::WORD_W] != sum[fxalu_pkg::WORD_W-1]) begin
          meta.simple = sum[fxalu_pkg::WORD_W] ? fxalu_pkg::SAT_MIN : fxalu_pkg::SAT_MAX;
        end else begin
          meta.simple = sum[fxalu_pkg::WORD_W-1:0];
        end
      end
      fxalu_pkg::OP_SUB: begin
        if (diff[fxalu_pkg::WORD_W] != diff[fxalu_pkg::WORD_W-1]) begin
          meta.simple = diff[fxalu_pkg::WORD_W] ? fxalu_pkg::SAT_MIN : fxalu_pkg::SAT_MAX;
        end else begin
          meta.simple = diff[fxalu_pkg::WORD_W-1:0];
        end
      end
      fxalu_pkg::OP_GT:       meta.cmp    = a > b;
      fxalu_pkg::OP_LT:       meta.cmp    = a < b;
      fxalu_pkg::OP_GE:       meta.cmp    = a >= b;
      fxalu_pkg::OP_LE:       meta.cmp    = a <= b;
      fxalu_pkg::OP_EQ:       meta.cmp    = a == b;
      fxalu_pkg::OP_NE:       meta.cmp    = a != b;
      fxalu_pkg::OP_INC:      meta.simple = a + fxalu_pkg::WORD_W'(1);
      fxalu_pkg::OP_DEC:      meta.simple = a - fxalu_pkg::WORD_W'(1);
      fxalu_pkg::OP_MIN:      meta.simple = (a < b) ? a : b;
      fxalu_pkg::OP_MAX:      meta.simple = (a > b) ? a : b;
      fxalu_pkg::OP_TO_INT:   meta.simple = fxalu_pkg::WORD_W'(a >>> FRAC_BITS);
      fxalu_pkg::OP_FROM_INT: meta.simple = fxalu_pkg::WORD_W'(a << FRAC_BITS);
      default:                meta.simple = '0;
    endcase
  end

endmodule

[sv/fxalu_div_cell.sv]
// One cell of the divider chain: a restoring step that yields one quotient bit
// and passes the item's side data on. Depends on fxalu_pkg.
`timescale 1ns / 1ps

module fxalu_div_cell #(
  parameter int NUM_W = fxalu_pkg::WORD_W + fxalu_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          valid_prev,
  input  fxalu_pkg::meta_t              meta_prev,
  input  logic [fxalu_pkg::WORD_W-1:0]  rem_prev,
  input  logic [NUM_W-1:0]              nq_prev,
  input  logic [fxalu_pkg::WORD_W-1:0]  den_prev,
  output logic                          valid,
  output fxalu_pkg::meta_t              meta,
  output logic [fxalu_pkg::WORD_W-1:0]  rem,
  output logic [NUM_W-1:0]              nq,
  output logic [fxalu_pkg::WORD_W-1:0]  den
);

  logic [fxalu_pkg::WORD_W:0] trial;
  logic                       qbit;

  assign trial = {rem_prev, nq_prev[NUM_W-1]};
  assign qbit  = trial >= {1'b0, den_prev};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta <= meta_prev;
      den  <= den_prev;
      rem  <= fxalu_pkg::WORD_W'(qbit ? trial - {1'b0, den_prev} : trial);
      nq   <= {nq_prev[NUM_W-2:0], qbit};
    end
  end

endmodule

[sv/fxalu_finish.sv]
// Back stage of the fixed-point unit: rounds and saturates the product and the
// quotient and selects the result. Depends on fxalu_pkg.
`timescale 1ns / 1ps

module fxalu_finish #(
  parameter int FRAC_BITS = fxalu_pkg::FRAC_BITS_DEF,
  parameter int NUM_W     = fxalu_pkg::WORD_W + FRAC_BITS
) (
  input  fxalu_pkg::meta_t              meta,
  input  logic [fxalu_pkg::WORD_W-1:0]  rem,
  input  logic [NUM_W-1:0]              quo,
  input  logic [fxalu_pkg::WORD_W-1:0]  den,
  output fxalu_pkg::rsp_t               rsp
);

  localparam logic [fxalu_pkg::PROD_W-1:0] HALF = (64'd1 << FRAC_BITS) >> 1;
  localparam logic [fxalu_pkg::PROD_W-1:0] LIM_POS =
    fxalu_pkg::PROD_W'(fxalu_pkg::SAT_MAX);
  localparam logic [fxalu_pkg::PROD_W-1:0] LIM_NEG =
    fxalu_pkg::PROD_W'(fxalu_pkg::SAT_MIN);

  logic [NUM_W:0]                quo_r;
  logic [fxalu_pkg::PROD_W-1:0]  prod_r;
  logic [fxalu_pkg::PROD_W-1:0]  mag;
  logic [fxalu_pkg::PROD_W-1:0]  limit;
  logic [fxalu_pkg::WORD_W-1:0]  arith;

  assign quo_r  = {1'b0, quo} + (NUM_W+1)'({rem, 1'b0} >= {1'b0, den});
  assign prod_r = (meta.prod + HALF) >> FRAC_BITS;
  assign mag    = (meta.op == fxalu_pkg::OP_DIV) ? fxalu_pkg::PROD_W'(quo_r) : prod_r;
  assign limit  = meta.neg ? LIM_NEG : LIM_POS;

  always_comb begin
    if (mag > limit) begin
      arith = meta.neg ? fxalu_pkg::SAT_MIN : fxalu_pkg::SAT_MAX;
    end else if (meta.neg) begin
      arith = fxalu_pkg::WORD_W'(-mag);
    end else begin
      arith = mag[fxalu_pkg::WORD_W-1:0];
    end
    rsp.compare_true   = meta.cmp;
    rsp.divide_by_zero = meta.dz;
    if (meta.dz) begin
      rsp.result_value = '0;
    end else if (meta.op == fxalu_pkg::OP_MUL || meta.op == fxalu_pkg::OP_DIV) begin
      rsp.result_value = arith;
    end else begin
      rsp.result_value = meta.simple;
    end
  end

endmodule

[sv/fxalu_checker.sv]
// Port-level checks for the fixed-point unit, bound to the top level.
// Depends on fxalu_pkg and fixed_point_alu_q24_8_unit.
`timescale 1ns / 1ps

module fxalu_checker (
  input logic            clk,
  input logic            rst,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input fxalu_pkg::rsp_t rsp
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result item dropped while stalled");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.divide_by_zero |-> rsp.result_value == '0)
    else $error("divide by zero with a non-zero result");

  a_cmp_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.compare_true |-> rsp.result_value == '0)
    else $error("comparison with a non-zero result");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.compare_true && rsp.divide_by_zero))
    else $error("comparison and divide by zero flagged together");

endmodule

bind fixed_point_alu_q24_8_unit fxalu_checker u_fxalu_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

[test/fixed_point_alu_q24_8_unit_tb.sv]
// Testbench for the Q24.8 fixed-point arithmetic unit.
// Drives items through valid/ready with random gaps and stalls, and checks every result
// against an in-order prediction. Depends on fxalu_pkg and fixed_point_alu_q24_8_unit.
`timescale 1ns / 1ps

module fixed_point_alu_q24_8_unit_tb;

  localparam int FB = fxalu_pkg::FRAC_BITS_DEF;
  localparam int LATENCY = fxalu_pkg::WORD_W + FB + 3;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  fxalu_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  fxalu_pkg::rsp_t rsp;

  fxalu_pkg::req_t pending_items[$];
  fxalu_pkg::rsp_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  int sent = 0;
  int issued = 0;
  int received = 0;
  int rsp_seen = 0;
  int in_wait = 0;
  int out_wait = 0;
  bit hold_off = 1'b0;

  fixed_point_alu_q24_8_unit u_dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [31:0] saturate(logic signed [65:0] v);
    if (v > 66'sd2147483647) return fxalu_pkg::SAT_MAX;
    if (v < -66'sd2147483648) return fxalu_pkg::SAT_MIN;
    return v[31:0];
  endfunction

  function automatic fxalu_pkg::rsp_t alu_predict(fxalu_pkg::req_t it);
    fxalu_pkg::rsp_t o;
    logic signed [65:0] a, b, s;
    logic [65:0] ma, mb, m, n;
    logic neg;
    o = '0;
    a = it.operand_a;
    b = it.operand_b;
    ma = a[65] ? -a : a;
    mb = b[65] ? -b : b;
    neg = a[65] ^ b[65];
    case (fxalu_pkg::op_t'(it.opcode))
      fxalu_pkg::OP_ADD: o.result_value = saturate(a + b);
      fxalu_pkg::OP_SUB: o.result_value = saturate(a - b);
      fxalu_pkg::OP_MUL: begin
        m = (ma * mb + (66'd1 << (FB - 1))) >> FB;
        s = neg ? -$signed(m) : $signed(m);
        o.result_value = saturate(s);
      end
      fxalu_pkg::OP_DIV: begin
        if (b == 0) begin
          o.divide_by_zero = 1'b1;
        end else begin
          n = ma << FB;
          m = (2 * n + mb) / (2 * mb);
          s = neg ? -$signed(m) : $signed(m);
          o.result_value = saturate(s);
        end
      end
      fxalu_pkg::OP_GT: o.compare_true = a > b;
      fxalu_pkg::OP_LT: o.compare_true = a < b;
      fxalu_pkg::OP_GE: o.compare_true = a >= b;
      fxalu_pkg::OP_LE: o.compare_true = a <= b;
      fxalu_pkg::OP_EQ: o.compare_true = a == b;
      fxalu_pkg::OP_NE: o.compare_true = a != b;
      fxalu_pkg::OP_INC: o.result_value = it.operand_a + 32'sd1;
      fxalu_pkg::OP_DEC: o.result_value = it.operand_a - 32'sd1;
      fxalu_pkg::OP_MIN: o.result_value = (a < b) ? it.operand_a : it.operand_b;
      fxalu_pkg::OP_MAX: o.result_value = (a > b) ? it.operand_a : it.operand_b;
      fxalu_pkg::OP_TO_INT: o.result_value = it.operand_a >>> FB;
      default: o.result_value = it.operand_a << FB;
    endcase
    return o;
  endfunction

  function automatic logic [31:0] random_operand();
    case ($urandom_range(0, 7))
      0: return fxalu_pkg::SAT_MAX - $urandom_range(0, 3);
      1: return fxalu_pkg::SAT_MIN + $urandom_range(0, 3);
      2: return $urandom_range(0, 4) - 2;
      3: return $signed($urandom_range(0, 2047)) - 1024;
      4: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(fxalu_pkg::op_t op, logic [31:0] a, logic [31:0] b);
    fxalu_pkg::req_t it;
    it.opcode = op;
    it.operand_a = a;
    it.operand_b = b;
    pending_items.push_back(it);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result %0d: %s got %h expected %h", received, what, got, want);
    errors++;
  endtask

  initial begin
    for (int k = 0; k < 16; k++) begin
      add_item(fxalu_pkg::op_t'(k), fxalu_pkg::SAT_MAX, fxalu_pkg::SAT_MIN);
    end
    add_item(fxalu_pkg::OP_DIV, 32'h100, 32'h0);
    add_item(fxalu_pkg::OP_DIV, fxalu_pkg::SAT_MIN, 32'hFFFF_FFFF);
    add_item(fxalu_pkg::OP_MUL, fxalu_pkg::SAT_MIN, fxalu_pkg::SAT_MIN);
    add_item(fxalu_pkg::OP_MUL, 32'hFFFF_FF80, 32'h1);
    add_item(fxalu_pkg::OP_INC, fxalu_pkg::SAT_MAX, 32'h0);
    add_item(fxalu_pkg::OP_DEC, fxalu_pkg::SAT_MIN, 32'h0);
    add_item(fxalu_pkg::OP_EQ, 32'h5, 32'h5);
    add_item(fxalu_pkg::OP_TO_INT, 32'hFFFF_FFFF, 32'h0);
    add_item(fxalu_pkg::OP_FROM_INT, 32'h00FF_FFFF, 32'h0);
    for (int k = 0; k < 400; k++) begin
      add_item(fxalu_pkg::op_t'($urandom_range(0, 15)), random_operand(), random_operand());
    end
  end

  // An offered item has been taken once the accept count catches up with the issue count.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || sent == issued) begin
      if (req_valid) begin
        in_wait = $urandom_range(0, 18);
      end
      if (in_wait > 0) begin
        in_wait--;
        req_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        req <= pending_items.pop_front();
        req_valid <= 1'b1;
        issued++;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) begin
      expected_results.push_back(alu_predict(req));
      sent++;
    end
  end

  always @(negedge clk) begin
    if (rst || hold_off) begin
      rsp_ready <= 1'b0;
    end else begin
      if (received != rsp_seen) begin
        rsp_seen = received;
        out_wait = $urandom_range(0, 18);
      end
      if (out_wait > 0) begin
        out_wait--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  initial begin
    wait (sent >= 60);
    hold_off = 1'b1;
    repeat (150) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    fxalu_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result_value", rsp.result_value, '0);
      end else begin
        want = expected_results.pop_front();
        if (rsp.result_value !== want.result_value)
          report_mismatch("result_value", rsp.result_value, want.result_value);
        if (rsp.compare_true !== want.compare_true)
          report_mismatch("compare_true", rsp.compare_true, want.compare_true);
        if (rsp.divide_by_zero !== want.divide_by_zero)
          report_mismatch("divide_by_zero", rsp.divide_by_zero, want.divide_by_zero);
      end
      received++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    wait (pending_items.size() == 0 && sent > 0);
    wait (!req_valid);
    wait (expected_results.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d items over all sixteen operations,", sent);
    $display("with random gaps, stalls and a long hold-off; %0d results checked", received);
    if (errors == 0 && expected_results.size() == 0 && received == sent) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

[sim.f]
sv/fxalu_pkg.sv
sv/fxalu_prep.sv
sv/fxalu_div_cell.sv
sv/fxalu_finish.sv
sv/fixed_point_alu_q24_8_unit.sv
sv/fxalu_checker.sv
test/fixed_point_alu_q24_8_unit_tb.sv
